>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the scheduler top level.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/ffts_pkg.sv
// ---------------------------------------------------------------------------
// ffts_pkg
// Types and constants shared by the frame tick scheduler modules.
// ---------------------------------------------------------------------------
package ffts_pkg;

  // Field widths
  localparam int RATE_W    = 19;
  localparam int WORD_W    = 32;
  localparam int PENDING_W = 64;
  localparam int CFG_IDX_W = 8;

  // Scaled timer ticks: 32-bit elapsed times 19-bit rate, plus remainder
  localparam int PROD_W    = WORD_W + RATE_W;
  localparam int DIV_BITS  = PROD_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);

  // Rate used when the sample rate register holds zero
  localparam logic [RATE_W-1:0] DEFAULT_RATE = RATE_W'(48000);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_HZ    = CFG_IDX_W'(1);

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_ACC,
    ST_TICK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul;
    logic div_init;
    logic div_step;
    logic acc;
    logic emit_frame;
    logic emit_fallback;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic timer_zero;
    logic div_done;
    logic has_frames;
    logic last_frame;
    logic fallback_ok;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/ffts_if.sv
// ---------------------------------------------------------------------------
// ffts channel interfaces
// Valid/ready channels for poll items, tick items and register writes.
// ---------------------------------------------------------------------------
interface ffts_poll_if;
  logic        valid;
  logic        ready;
  logic [31:0] timer_now;
  logic [31:0] ms_now;

  modport source (output valid, output timer_now, output ms_now, input ready);
  modport sink   (input valid, input timer_now, input ms_now, output ready);
endinterface

interface ffts_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] delta_ms;
  logic [31:0] tick_number;
  logic        last;

  modport source (output valid, output delta_ms, output tick_number, output last,
                  input ready);
  modport sink   (input valid, input delta_ms, input tick_number, input last,
                  output ready);
endinterface

interface ffts_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/ffts_dpath.sv
// ---------------------------------------------------------------------------
// ffts_dpath
// Scheduler datapath: config registers, rate multiplier, serial divider,
// pending frame accumulator and tick output register.
// ---------------------------------------------------------------------------
module ffts_dpath import ffts_pkg::*; #(
  parameter int MAX_TICKS_PER_POLL = 8,
  parameter int FRAMES_PER_TICK    = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [WORD_W-1:0] timer_now,
  input  logic [WORD_W-1:0] ms_now,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  ffts_cfg_if.sink          cfg,
  ffts_tick_if.source       tick
);

  localparam int CNT_W = $clog2(MAX_TICKS_PER_POLL + 1);
  localparam logic [PENDING_W-1:0] FPT     = PENDING_W'(FRAMES_PER_TICK);
  localparam logic [PENDING_W-1:0] FPT_X2  = PENDING_W'(2 * FRAMES_PER_TICK);
  localparam logic [CNT_W-1:0]     CNT_END = CNT_W'(MAX_TICKS_PER_POLL - 1);

  // Config and persistent state
  logic [RATE_W-1:0]    sample_rate_hz;
  logic [WORD_W-1:0]    timer_hz;
  logic [WORD_W-1:0]    previous_timer;
  logic [WORD_W-1:0]    frame_remainder;
  logic [PENDING_W-1:0] frames_pending;
  logic [WORD_W-1:0]    previous_ms;
  logic [WORD_W-1:0]    tick_total;
  logic                 out_valid;

  // Per-poll working registers
  logic [WORD_W-1:0]    tnow;
  logic [WORD_W-1:0]    mnow;
  logic [CNT_W-1:0]     cnt;
  logic [PROD_W-1:0]    prod;
  logic [DIV_BITS-1:0]  quo;
  logic [WORD_W-1:0]    prem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [WORD_W-1:0]    out_delta;
  logic [WORD_W-1:0]    out_number;
  logic                 out_last;

  // Combinational helpers
  logic [RATE_W-1:0]    rate_eff;
  logic [WORD_W-1:0]    elapsed;
  logic [WORD_W:0]      trial;
  logic                 trial_ge;
  logic [PENDING_W:0]   pend_sum;
  logic [WORD_W-1:0]    dms_raw;
  logic [WORD_W-1:0]    dms;
  logic [WORD_W-1:0]    tick_total_next;

  assign rate_eff = (sample_rate_hz != '0) ? sample_rate_hz : DEFAULT_RATE;
  assign elapsed  = tnow - previous_timer;

  // Divider step: shift in the next dividend bit, try to subtract
  assign trial    = {prem, quo[DIV_BITS-1]};
  assign trial_ge = trial >= {1'b0, timer_hz};

  assign pend_sum = {1'b0, frames_pending} + PENDING_W'(quo) ;
  assign dms_raw  = mnow - previous_ms;
  assign dms      = (dms_raw == '0) ? WORD_W'(1) : dms_raw;
  assign tick_total_next = tick_total + WORD_W'(1);

  // Status to controller
  assign status.timer_zero  = timer_hz == '0;
  assign status.div_done    = div_cnt == DIV_CNT_W'(DIV_BITS - 1);
  assign status.has_frames  = frames_pending >= FPT;
  assign status.last_frame  = (cnt == CNT_END) || (frames_pending < FPT_X2);
  assign status.fallback_ok = (cnt == '0) && (timer_hz == '0) && (dms_raw != '0);
  assign status.out_free    = !out_valid || tick.ready;

  // Config port never stalls
  assign cfg.ready = 1'b1;

  // Tick output register
  assign tick.valid       = out_valid;
  assign tick.delta_ms    = out_delta;
  assign tick.tick_number = out_number;
  assign tick.last        = out_last;

  // Control and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate_hz  <= DEFAULT_RATE;
      timer_hz        <= '0;
      previous_timer  <= '0;
      frame_remainder <= '0;
      frames_pending  <= '0;
      previous_ms     <= '0;
      tick_total      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_SAMPLE_RATE: sample_rate_hz <= cfg.data[RATE_W-1:0];
          REG_TIMER_HZ:    timer_hz       <= cfg.data;
          default: ;
        endcase
      end

      if (cmd.acc) begin
        previous_timer  <= tnow;
        frame_remainder <= prem;
        frames_pending  <= pend_sum[PENDING_W] ? '1 : pend_sum[PENDING_W-1:0];
      end

      if (cmd.emit_frame) begin
        frames_pending <= frames_pending - FPT;
      end

      if (cmd.emit_frame || cmd.emit_fallback) begin
        previous_ms <= mnow;
        tick_total  <= tick_total_next;
        out_valid   <= 1'b1;
      end else if (tick.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and tick payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tnow <= timer_now;
      mnow <= ms_now;
      cnt  <= '0;
    end

    // 32 x 19 multiply, registered
    if (cmd.mul) begin
      prod <= PROD_W'(elapsed) * PROD_W'(rate_eff);
    end

    if (cmd.div_init) begin
      quo     <= DIV_BITS'(prod) + DIV_BITS'(frame_remainder);
      prem    <= '0;
      div_cnt <= '0;
    end

    // One quotient bit per cycle, quotient shifts into the dividend register
    if (cmd.div_step) begin
      prem    <= trial_ge ? WORD_W'(trial - {1'b0, timer_hz}) : trial[WORD_W-1:0];
      quo     <= {quo[DIV_BITS-2:0], trial_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end

    if (cmd.emit_frame) begin
      out_delta  <= dms;
      out_number <= tick_total_next;
      out_last   <= status.last_frame;
      cnt        <= cnt + CNT_W'(1);
    end else if (cmd.emit_fallback) begin
      out_delta  <= dms_raw;
      out_number <= tick_total_next;
      out_last   <= 1'b1;
    end
  end

endmodule

>>> rtl/ffts_ctrl.sv
// ---------------------------------------------------------------------------
// ffts_ctrl
// Scheduler controller: sequences multiply, divide, accumulate and the
// tick emission loop for one poll item at a time.
// ---------------------------------------------------------------------------
module ffts_ctrl import ffts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.timer_zero ? ST_TICK : ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC:  state_next = ST_TICK;
      ST_TICK: begin
        if (status.has_frames) begin
          if (status.out_free && status.last_frame) begin
            state_next = ST_IDLE;
          end
        end else if (status.fallback_ok) begin
          if (status.out_free) begin
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_MUL:  cmd.mul      = 1'b1;
      ST_LOAD: cmd.div_init = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_ACC:  cmd.acc      = 1'b1;
      ST_TICK: begin
        cmd.emit_frame    = status.has_frames && status.out_free;
        cmd.emit_fallback = !status.has_frames && status.fallback_ok && status.out_free;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/fractional_frame_tick_scheduler.sv
// ---------------------------------------------------------------------------
// fractional_frame_tick_scheduler
// Turns timer captures into audio frame ticks. Each poll item scales the
// elapsed timer count by the sample rate, divides by the timer frequency
// with the remainder carried over, adds the quotient to the pending frames
// and emits up to MAX_TICKS_PER_POLL tick items of FRAMES_PER_TICK frames
// each; the last tick of a poll has last set. With timer_hz at zero a poll
// emits one tick whenever ms_now has moved, once pending frames are used up.
// One poll is processed at a time: in timer mode the controller steps through
// multiply, divider load, the 52-step serial divider, accumulate and then the
// tick loop, which waits while the tick consumer stalls; in millisecond mode
// it goes straight to the tick loop.
// The next poll is taken while the final tick still waits in the output
// register. Register writes are taken every cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fractional_frame_tick_scheduler import ffts_pkg::*; #(
  parameter int MAX_TICKS_PER_POLL = 8,
  parameter int FRAMES_PER_TICK    = 32
) (
  input  logic         clk,
  input  logic         rst,
  ffts_cfg_if.sink     cfg,
  ffts_poll_if.sink    poll,
  ffts_tick_if.source  tick
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign poll.ready = in_ready;

  // Sequencer
  ffts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (poll.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and state
  ffts_dpath #(
    .MAX_TICKS_PER_POLL (MAX_TICKS_PER_POLL),
    .FRAMES_PER_TICK    (FRAMES_PER_TICK)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .timer_now (poll.timer_now),
    .ms_now    (poll.ms_now),
    .cmd       (cmd),
    .status    (status),
    .cfg       (cfg),
    .tick      (tick)
  );

  // A poll is never overlapped by the next one
  `ASSERT_NEXT(a_poll_busy, clk, rst, poll.valid && poll.ready, !poll.ready)
  // Divider runs only with no poll being taken
  `ASSERT_IMPLY(a_div_busy, clk, rst, cmd.div_step, !poll.ready)
  // A tick is loaded only into a free output register
  `ASSERT_IMPLY(a_emit_free, clk, rst, cmd.emit_frame || cmd.emit_fallback, status.out_free)
  // Frame ticks only while a full tick of frames is pending
  `ASSERT_IMPLY(a_emit_frames, clk, rst, cmd.emit_frame, status.has_frames)

endmodule
